>>> rtl/glig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glig_pkg
// Shared types and constants of the grid level-of-detail index generator.
// ----------------------------------------------------------------------------
package glig_pkg;

  // Grid limits.
  localparam int unsigned MAX_QUADS_PER_SIDE = 256;
  localparam int unsigned LOD_LEVELS         = 4;
  localparam int unsigned BQ_W               = $clog2(MAX_QUADS_PER_SIDE + 1);
  localparam int unsigned CELL_W             = $clog2(MAX_QUADS_PER_SIDE);
  localparam int unsigned LOD_W              = $clog2(LOD_LEVELS);
  localparam int unsigned IDX_W              = 17;
  localparam int unsigned MAX_SKIP           = 1 << (LOD_LEVELS - 1);
  localparam int unsigned SKIP_W             = $clog2(MAX_SKIP);

  // Command queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] REG_LOD_LEVEL         = 2'd1;
  localparam logic [1:0] REG_HOLE_ENABLE       = 2'd2;

  localparam logic [8:0] BASE_VERTEX_COUNT_RST = 9'd257;

  // Command codes.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EMIT  = 1'b1
  } cmd_e;

  // Input transaction.
  typedef struct packed {
    logic              command;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_z;
    logic              hole_value;
  } cmd_t;

  // Result transaction.
  typedef struct packed {
    logic [IDX_W-1:0] tri0_first;
    logic [IDX_W-1:0] tri0_second;
    logic [IDX_W-1:0] tri0_third;
    logic [IDX_W-1:0] tri1_first;
    logic [IDX_W-1:0] tri1_second;
    logic [IDX_W-1:0] tri1_third;
  } result_t;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic [8:0]       base_vertex_count;
    logic [LOD_W-1:0] lod_level;
    logic             hole_enable;
  } cfg_t;

  // Classified command held in the queue.
  typedef struct packed {
    cmd_e              op;
    logic              check;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_z;
    logic              hole_value;
    logic [LOD_W-1:0]  lod;
    logic [BQ_W-1:0]   vert_count;
  } q_entry_t;

  // Column mask of one skip-wide window, lowest bits set.
  function automatic logic [MAX_SKIP-1:0] skip_mask(input logic [LOD_W-1:0] lod);
    logic [MAX_SKIP:0] one_hot;
    one_hot   = (MAX_SKIP + 1)'(1) << ((SKIP_W + 1)'(1) << lod);
    skip_mask = MAX_SKIP'(one_hot - (MAX_SKIP + 1)'(1));
  endfunction

endpackage

>>> rtl/grid_lod_index_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_lod_index_generator
// Hole map of base grid cells and triangle index generation for one quad of
// the selected level of detail, with an APB-style configuration port.
// ----------------------------------------------------------------------------
// After reset the block clears its 256-row hole map, one row per cycle, and
// holds busy high until the clear is done; configuration writes are taken
// during that time. A command is taken when start is high and busy is low; a
// two-entry queue lets up to two commands wait while an earlier one executes.
// A hole write is a read-modify-write of one row word. An emit computes the
// corner indices and, with hole checking on, scans the rows of the quad, one
// row word per cycle through the single read port; the result then appears on
// result_o for exactly one cycle with result_valid_o high. The receiver cannot
// stall results, so they must be taken as they come. Commands outside the grid
// or the level, and emits over a hole, give no result.
// ----------------------------------------------------------------------------
module grid_lod_index_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Command channel.
  input  logic              start,
  input  glig_pkg::cmd_t    cmd_i,
  output logic              busy,
  // Result channel.
  output logic              result_valid_o,
  output glig_pkg::result_t result_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  glig_pkg::cfg_t     cfg_q;
  glig_pkg::q_entry_t push_entry;
  glig_pkg::q_entry_t pop_entry;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  logic               clearing;
  logic               cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_vertex_count <= glig_pkg::BASE_VERTEX_COUNT_RST;
      cfg_q.lod_level         <= '0;
      cfg_q.hole_enable       <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        glig_pkg::REG_BASE_VERTEX_COUNT: cfg_q.base_vertex_count <= pwdata[8:0];
        glig_pkg::REG_LOD_LEVEL:         cfg_q.lod_level <= pwdata[glig_pkg::LOD_W-1:0];
        glig_pkg::REG_HOLE_ENABLE:       cfg_q.hole_enable <= pwdata[0];
        default:                         cfg_q <= cfg_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      glig_pkg::REG_BASE_VERTEX_COUNT: prdata = 32'(cfg_q.base_vertex_count);
      glig_pkg::REG_LOD_LEVEL:         prdata = 32'(cfg_q.lod_level);
      glig_pkg::REG_HOLE_ENABLE:       prdata = 32'(cfg_q.hole_enable);
      default:                         prdata = '0;
    endcase
  end

  // Command classification.
  glig_front u_front (
    .start      (start),
    .cmd_i      (cmd_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .busy       (busy),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Command queue.
  glig_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Command execution and hole map.
  glig_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (pop_entry),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

>>> rtl/glig_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glig_front
// Accepts commands, checks them against the grid bounds and queues the ones
// that have work to do.
// ----------------------------------------------------------------------------
module glig_front (
  input  logic              start,
  input  glig_pkg::cmd_t    cmd_i,
  input  glig_pkg::cfg_t    cfg_i,
  input  logic              q_full_i,
  input  logic              clearing_i,
  output logic              busy,
  output logic              push_o,
  output glig_pkg::q_entry_t entry_o
);

  logic [glig_pkg::BQ_W-1:0] base_quads;
  logic [glig_pkg::BQ_W-1:0] level_quads;
  logic [glig_pkg::BQ_W-1:0] cx_ext;
  logic [glig_pkg::BQ_W-1:0] cz_ext;
  logic                      in_base;
  logic                      in_level;
  logic                      lod_ok;
  logic                      accept;

  // Base quad count, saturated at the grid size.
  always_comb begin
    if (cfg_i.base_vertex_count < 9'd2) begin
      base_quads = '0;
    end else if ((cfg_i.base_vertex_count - 9'd1) >
                 glig_pkg::BQ_W'(glig_pkg::MAX_QUADS_PER_SIDE)) begin
      base_quads = glig_pkg::BQ_W'(glig_pkg::MAX_QUADS_PER_SIDE);
    end else begin
      base_quads = glig_pkg::BQ_W'(cfg_i.base_vertex_count - 9'd1);
    end
  end

  // Bounds classification.
  assign level_quads = base_quads >> cfg_i.lod_level;
  assign cx_ext      = glig_pkg::BQ_W'(cmd_i.cell_x);
  assign cz_ext      = glig_pkg::BQ_W'(cmd_i.cell_z);
  assign in_base     = (cx_ext < base_quads) && (cz_ext < base_quads);
  assign in_level    = (cx_ext < level_quads) && (cz_ext < level_quads);
  assign lod_ok      = 32'(cfg_i.lod_level) < glig_pkg::LOD_LEVELS;

  // A command is taken only when the queue has room and the map is ready.
  assign busy   = q_full_i || clearing_i;
  assign accept = start && !busy;

  always_comb begin
    entry_o.op         = glig_pkg::cmd_e'(cmd_i.command);
    entry_o.check      = cfg_i.hole_enable;
    entry_o.cell_x     = cmd_i.cell_x;
    entry_o.cell_z     = cmd_i.cell_z;
    entry_o.hole_value = cmd_i.hole_value;
    entry_o.lod        = cfg_i.lod_level;
    entry_o.vert_count = level_quads + glig_pkg::BQ_W'(1);
    case (glig_pkg::cmd_e'(cmd_i.command))
      glig_pkg::CMD_WRITE: push_o = accept && in_base;
      glig_pkg::CMD_EMIT:  push_o = accept && in_level && lod_ok;
      default:             push_o = 1'b0;
    endcase
  end

endmodule

>>> rtl/glig_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glig_queue
// Short FIFO that decouples command classification from execution.
// ----------------------------------------------------------------------------
module glig_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  glig_pkg::q_entry_t push_data_i,
  input  logic               pop_i,
  output glig_pkg::q_entry_t pop_data_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam logic [glig_pkg::Q_PTR_W-1:0] LastPtr = glig_pkg::Q_PTR_W'(glig_pkg::Q_DEPTH - 1);

  glig_pkg::q_entry_t                slots_q [glig_pkg::Q_DEPTH];
  logic [glig_pkg::Q_PTR_W-1:0]      wr_ptr_q;
  logic [glig_pkg::Q_PTR_W-1:0]      rd_ptr_q;
  logic [glig_pkg::Q_CNT_W-1:0]      count_q;

  assign full_o     = count_q == glig_pkg::Q_CNT_W'(glig_pkg::Q_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = slots_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + glig_pkg::Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + glig_pkg::Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + glig_pkg::Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - glig_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/glig_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glig_back
// Executes queued commands: hole map writes, hole scans and index emission.
// Owns the row-organized hole map and its clearing pass after reset.
// ----------------------------------------------------------------------------
module glig_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  glig_pkg::q_entry_t q_data_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               result_valid_o,
  output glig_pkg::result_t  result_o
);

  localparam int unsigned RowW = glig_pkg::MAX_QUADS_PER_SIDE;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_WR_READ,
    ST_WR_WRITE
  } state_e;

  state_e                         state_q;
  glig_pkg::q_entry_t             ent_q;
  logic [glig_pkg::CELL_W-1:0]    clr_row_q;
  logic [glig_pkg::SKIP_W-1:0]    row_cnt_q;
  logic                           chk_q;
  logic                           hole_q;
  logic [glig_pkg::IDX_W-1:0]     prod_q;
  logic [glig_pkg::IDX_W-1:0]     tl_q;
  logic                           res_valid_q;
  glig_pkg::result_t              res_q;

  // Hole map: one row word per base row.
  logic [RowW-1:0]                mem [glig_pkg::MAX_QUADS_PER_SIDE];
  logic [RowW-1:0]                mem_rdata_q;
  logic                           mem_re;
  logic [glig_pkg::CELL_W-1:0]    mem_raddr;
  logic                           mem_we;
  logic [glig_pkg::CELL_W-1:0]    mem_waddr;
  logic [RowW-1:0]                mem_wdata;

  logic [glig_pkg::CELL_W-1:0]    row0;
  logic [glig_pkg::CELL_W-1:0]    col0;
  logic [glig_pkg::SKIP_W-1:0]    last_row;
  logic [glig_pkg::MAX_SKIP-1:0]  window;
  logic                           hit;
  logic [glig_pkg::IDX_W-1:0]     tr;
  logic [glig_pkg::IDX_W-1:0]     bl;
  logic [glig_pkg::IDX_W-1:0]     br;

  assign pop_o          = (state_q == ST_IDLE) && !q_empty_i;
  assign clearing_o     = state_q == ST_CLEAR;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Window of the quad in base cells.
  assign row0     = glig_pkg::CELL_W'(ent_q.cell_z << ent_q.lod);
  assign col0     = glig_pkg::CELL_W'(ent_q.cell_x << ent_q.lod);
  assign last_row = glig_pkg::SKIP_W'((4'd1 << ent_q.lod) - 4'd1);

  // Hole test on the row word read in the previous cycle.
  assign window = glig_pkg::MAX_SKIP'(mem_rdata_q >> col0) & glig_pkg::skip_mask(ent_q.lod);
  assign hit    = chk_q && (|window);

  // Vertex indices of the quad corners.
  assign tr = tl_q + glig_pkg::IDX_W'(1);
  assign bl = tl_q + glig_pkg::IDX_W'(ent_q.vert_count);
  assign br = bl + glig_pkg::IDX_W'(1);

  // Memory port control.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ent_q.cell_z;
    mem_we    = 1'b0;
    mem_waddr = ent_q.cell_z;
    mem_wdata = mem_rdata_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row_q;
        mem_wdata = '0;
      end
      ST_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = row0 + glig_pkg::CELL_W'(row_cnt_q);
      end
      ST_WR_READ: begin
        mem_re = 1'b1;
      end
      ST_WR_WRITE: begin
        mem_we                  = 1'b1;
        mem_wdata[ent_q.cell_x] = ent_q.hole_value;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Hole map storage.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= q_data_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= glig_pkg::IDX_W'(ent_q.cell_z) * glig_pkg::IDX_W'(ent_q.vert_count);
    end
    if (state_q == ST_ADD) begin
      tl_q <= prod_q + glig_pkg::IDX_W'(ent_q.cell_x);
    end
    if (state_q == ST_EMIT) begin
      res_q.tri0_first  <= tl_q;
      res_q.tri0_second <= bl;
      res_q.tri0_third  <= tr;
      res_q.tri1_first  <= tr;
      res_q.tri1_second <= bl;
      res_q.tri1_third  <= br;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_row_q   <= '0;
      row_cnt_q   <= '0;
      chk_q       <= 1'b0;
      hole_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_row_q <= clr_row_q + glig_pkg::CELL_W'(1);
          if (clr_row_q == glig_pkg::CELL_W'(glig_pkg::MAX_QUADS_PER_SIDE - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          row_cnt_q <= '0;
          chk_q     <= 1'b0;
          hole_q    <= 1'b0;
          if (pop_o) begin
            state_q <= (q_data_i.op == glig_pkg::CMD_WRITE) ? ST_WR_READ : ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          state_q <= ent_q.check ? ST_SCAN : ST_EMIT;
        end
        ST_SCAN: begin
          chk_q     <= 1'b1;
          row_cnt_q <= row_cnt_q + glig_pkg::SKIP_W'(1);
          if (hit) begin
            hole_q <= 1'b1;
          end
          if (row_cnt_q == last_row) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          chk_q   <= 1'b0;
          state_q <= (hit || hole_q) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_WR_READ: begin
          state_q <= ST_WR_WRITE;
        end
        ST_WR_WRITE: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
